>>> hw/rtl/edc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edc_pkg
// Shared constants and the CORDIC phase table for the Euler-to-DCM block.
// ----------------------------------------------------------------------------
package edc_pkg;

  localparam int unsigned NumSteps  = 30;  // CORDIC rotations
  localparam int unsigned PhaseBits = 32;  // 2^32 is one full turn
  localparam int unsigned QBits     = 32;  // width of a clamped Q30 value
  localparam int unsigned CordicW   = 34;  // x, y, z working width

  localparam logic signed [CordicW-1:0] GainInv = 34'sd652032874;
  localparam logic signed [QBits-1:0]   Q30One  = 32'sd1073741824;

  typedef logic signed [QBits-1:0] q30_t;

  // atan(2^-i) in units of 2^-32 turn, rounded
  function automatic logic [29:0] cordic_atan(input logic [4:0] idx);
    logic [29:0] t;
    case (idx)
      5'd0:  t = 30'd536870912;
      5'd1:  t = 30'd316933406;
      5'd2:  t = 30'd167458907;
      5'd3:  t = 30'd85004756;
      5'd4:  t = 30'd42667331;
      5'd5:  t = 30'd21354465;
      5'd6:  t = 30'd10679838;
      5'd7:  t = 30'd5340245;
      5'd8:  t = 30'd2670163;
      5'd9:  t = 30'd1335087;
      5'd10: t = 30'd667544;
      5'd11: t = 30'd333772;
      5'd12: t = 30'd166886;
      5'd13: t = 30'd83443;
      5'd14: t = 30'd41722;
      5'd15: t = 30'd20861;
      5'd16: t = 30'd10430;
      5'd17: t = 30'd5215;
      5'd18: t = 30'd2608;
      5'd19: t = 30'd1304;
      5'd20: t = 30'd652;
      5'd21: t = 30'd326;
      5'd22: t = 30'd163;
      5'd23: t = 30'd81;
      5'd24: t = 30'd41;
      5'd25: t = 30'd20;
      5'd26: t = 30'd10;
      5'd27: t = 30'd5;
      5'd28: t = 30'd3;
      5'd29: t = 30'd1;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/edc_cordic_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edc_cordic_lane
// Pipelined sine/cosine of one binary angle: range reduction, 30 CORDIC
// stages, quadrant fold and clamp. Every register advances only with en_i.
// ----------------------------------------------------------------------------
module edc_cordic_lane #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  wire                     clk_i,
  input  wire                     en_i,
  input  wire  [ANGLE_BITS-1:0]   angle_i,
  output edc_pkg::q30_t           sin_o,
  output edc_pkg::q30_t           cos_o
);
  import edc_pkg::*;

  logic [PhaseBits-1:0] phase;
  logic [1:0]           quad;
  logic [PhaseBits-1:0] rem;

  logic signed [CordicW-1:0] x_q [0:NumSteps];
  logic signed [CordicW-1:0] y_q [0:NumSteps];
  logic signed [CordicW-1:0] z_q [0:NumSteps];
  logic [1:0]                quad_q [0:NumSteps];
  q30_t                      sin_q, cos_q;

  // reduce to [-pi/4, pi/4) and the quadrant
  always_comb begin
    phase = {angle_i, {(PhaseBits-ANGLE_BITS){1'b0}}};
    quad  = 2'(32'(phase + 32'h2000_0000) >> 30);
    rem   = phase - {quad, 30'd0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= GainInv;
      y_q[0]    <= '0;
      z_q[0]    <= CordicW'($signed(rem));
      quad_q[0] <= quad;
    end
  end

  for (genvar i = 0; i < NumSteps; i++) begin : g_step
    logic signed [CordicW-1:0] dx, dy, t;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign t  = $signed({4'd0, cordic_atan(5'(i))});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][CordicW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - t;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + t;
        end
        quad_q[i+1] <= quad_q[i];
      end
    end
  end

  function automatic q30_t clamp(input logic signed [CordicW-1:0] v);
    if (v > CordicW'(Q30One))  return Q30One;
    if (v < -CordicW'(Q30One)) return -Q30One;
    return QBits'(v);
  endfunction

  logic signed [CordicW-1:0] xf, yf;
  assign xf = x_q[NumSteps];
  assign yf = y_q[NumSteps];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_q[NumSteps])
        2'd0: begin cos_q <= clamp(xf);  sin_q <= clamp(yf);  end
        2'd1: begin cos_q <= clamp(-yf); sin_q <= clamp(xf);  end
        2'd2: begin cos_q <= clamp(-xf); sin_q <= clamp(-yf); end
        default: begin cos_q <= clamp(yf); sin_q <= clamp(-xf); end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

>>> hw/rtl/edc_dcm_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edc_dcm_merge
// Combine the three lanes' sines and cosines into the nine DCM entries:
// two product stages and a sum/round/saturate stage.
// ----------------------------------------------------------------------------
module edc_dcm_merge #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire                        clk_i,
  input  wire                        en_i,
  input  edc_pkg::q30_t              sr_i,
  input  edc_pkg::q30_t              cr_i,
  input  edc_pkg::q30_t              sp_i,
  input  edc_pkg::q30_t              cp_i,
  input  edc_pkg::q30_t              sy_i,
  input  edc_pkg::q30_t              cy_i,
  output logic [9*(FRAC_BITS+2)-1:0] dcm_o
);
  import edc_pkg::*;

  localparam int unsigned OutW = FRAC_BITS + 2;
  localparam int unsigned Sh   = 30 - FRAC_BITS;
  localparam logic signed [33:0] Half = (34'sd1 <<< Sh) >>> 1;
  localparam logic signed [33:0] Lim  = 34'sd1 <<< FRAC_BITS;

  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return QBits'(p >>> 30);
  endfunction

  function automatic logic [OutW-1:0] to_out(input logic signed [32:0] v);
    logic signed [33:0] r;
    r = (34'(v) + Half) >>> Sh;
    if (r > Lim)  r = Lim;
    if (r < -Lim) r = -Lim;
    return r[OutW-1:0];
  endfunction

  // stage 1
  q30_t cysp_q, sysp_q, cycp_q, sycp_q, sycr_q, cycr_q, cpsr_q, sysr_q, cysr_q, cpcr_q;
  q30_t sr1_q, cr1_q, sp1_q;
  // stage 2
  q30_t a_q, b_q, c_q, d_q;
  q30_t cycp2_q, sycp2_q, sycr2_q, cycr2_q, cpsr2_q, sysr2_q, cysr2_q, cpcr2_q, sp2_q;
  logic [9*OutW-1:0] dcm_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cysp_q <= qmul(cy_i, sp_i);
      sysp_q <= qmul(sy_i, sp_i);
      cycp_q <= qmul(cy_i, cp_i);
      sycp_q <= qmul(sy_i, cp_i);
      sycr_q <= qmul(sy_i, cr_i);
      cycr_q <= qmul(cy_i, cr_i);
      cpsr_q <= qmul(cp_i, sr_i);
      sysr_q <= qmul(sy_i, sr_i);
      cysr_q <= qmul(cy_i, sr_i);
      cpcr_q <= qmul(cp_i, cr_i);
      sr1_q  <= sr_i;
      cr1_q  <= cr_i;
      sp1_q  <= sp_i;

      a_q <= qmul(cysp_q, sr1_q);
      b_q <= qmul(sysp_q, sr1_q);
      c_q <= qmul(cysp_q, cr1_q);
      d_q <= qmul(sysp_q, cr1_q);
      cycp2_q <= cycp_q;  sycp2_q <= sycp_q;  sycr2_q <= sycr_q;
      cycr2_q <= cycr_q;  cpsr2_q <= cpsr_q;  sysr2_q <= sysr_q;
      cysr2_q <= cysr_q;  cpcr2_q <= cpcr_q;  sp2_q   <= sp1_q;

      dcm_q <= {to_out(33'(cpcr2_q)),
                to_out(33'(d_q) - 33'(cysr2_q)),
                to_out(33'(c_q) + 33'(sysr2_q)),
                to_out(33'(cpsr2_q)),
                to_out(33'(b_q) + 33'(cycr2_q)),
                to_out(33'(a_q) - 33'(sycr2_q)),
                to_out(-33'(sp2_q)),
                to_out(33'(sycp2_q)),
                to_out(33'(cycp2_q))};
    end
  end

  assign dcm_o = dcm_q;

endmodule
`default_nettype wire

>>> hw/rtl/euler_to_direction_cosine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_direction_cosine
// 3-2-1 Euler angles to the direction cosine matrix in signed Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
//  channel  dir  fields (tdata, low bits first)
//  s_axis   in   roll_angle, pitch_angle, yaw_angle (ANGLE_BITS each)
//  m_axis   out  dcm_r0c0 .. dcm_r2c2 row by row (FRAC_BITS+2 each)
//
//  One request per cycle sustained while m_axis is not stalled; the three
//  CORDIC lanes run in parallel, followed by the product/merge stages.
//  The pipeline advances as one unit whenever the output register is empty
//  or being taken; a stall at m_axis holds every stage.
//  Reset clears only the valid chain; datapath registers are not reset.
// ----------------------------------------------------------------------------
module euler_to_direction_cosine #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned FRAC_BITS  = 14
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  // roll_angle, pitch_angle, yaw_angle, zero fill
  input  wire  [((3*ANGLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  // dcm_r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2, zero fill
  output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0]   m_axis_tdata
);
  import edc_pkg::*;

  localparam int unsigned Lat  = NumSteps + 2 + 3;
  localparam int unsigned DcmW = 9 * (FRAC_BITS + 2);
  localparam int unsigned OutW = ((DcmW + 7) / 8) * 8;

  logic [Lat-1:0] vld_q, vld_d;
  logic           adv;
  q30_t           sr, cr, sp, cp, sy, cy;
  logic [DcmW-1:0] dcm;

  // advance when the output slot is free or drains this cycle
  assign adv           = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign vld_d         = adv ? {vld_q[Lat-2:0], s_axis_tvalid} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  edc_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk_i, .en_i(adv), .angle_i(s_axis_tdata[ANGLE_BITS-1:0]),
    .sin_o(sr), .cos_o(cr)
  );
  edc_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk_i, .en_i(adv), .angle_i(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
    .sin_o(sp), .cos_o(cp)
  );
  edc_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk_i, .en_i(adv), .angle_i(s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
    .sin_o(sy), .cos_o(cy)
  );

  // merge the lanes into the nine matrix entries
  edc_dcm_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk_i, .en_i(adv),
    .sr_i(sr), .cr_i(cr), .sp_i(sp), .cp_i(cp), .sy_i(sy), .cy_i(cy),
    .dcm_o(dcm)
  );

  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata  = OutW'(dcm);

endmodule
`default_nettype wire

>>> hw/rtl/edc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edc_checker
// Port-level checks for euler_to_direction_cosine, bound to the top level.
// ----------------------------------------------------------------------------
module edc_checker #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned FRAC_BITS  = 14
) (
  input wire                                    clk_i,
  input wire                                    rst_ni,
  input wire                                    s_axis_tvalid,
  input wire                                    s_axis_tready,
  input wire [((3*ANGLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  input wire                                    m_axis_tvalid,
  input wire                                    m_axis_tready,
  input wire [((9*(FRAC_BITS+2)+7)/8)*8-1:0]    m_axis_tdata
);
  localparam int unsigned W = FRAC_BITS + 2;
  localparam logic signed [W-1:0] Lim = W'(1) << FRAC_BITS;

  logic in_range;
  always_comb begin
    in_range = 1'b1;
    for (int k = 0; k < 9; k++) begin
      if ($signed(m_axis_tdata[k*W +: W]) > Lim ||
          $signed(m_axis_tdata[k*W +: W]) < -Lim) in_range = 1'b0;
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("request changed while waiting");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> in_range)
    else $error("matrix entry beyond unit magnitude");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

endmodule

bind euler_to_direction_cosine edc_checker #(
  .ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)
) u_edc_checker (.*);
`default_nettype wire
